/* hdl/jsu_pkg.sv */
`default_nettype none

package jsu_pkg;

  // Result kinds, carried on the result channel's tuser.
  typedef enum logic [1:0] {
    KIND_TEXT   = 2'd0,
    KIND_CLOSED = 2'd1,
    KIND_NOTSTR = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  // Error codes reported with a result of kind error.
  typedef enum logic [2:0] {
    ERR_NONE = 3'd0,
    ERR_EOI  = 3'd1,
    ERR_CTRL = 3'd2,
    ERR_ESC  = 3'd3,
    ERR_HEX  = 3'd4
  } err_t;

  // Largest code point after surrogate pairing is 21 bits wide.
  localparam int unsigned CP_W = 21;

  // UTF-8 encoding of one code point: byte 0 goes out first.
  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] bytes;
  } utf8_t;

  // One request's worth of results, queued between parser and serializer.
  // Text bytes come first, then an optional closing, not-a-string or error result.
  typedef struct packed {
    logic [2:0]      n_text;
    logic [3:0][7:0] text;
    logic            tail_vld;
    kind_t           tail_kind;
    err_t            tail_err;
  } entry_t;

  // Encode a code point into one to four UTF-8 bytes.
  function automatic utf8_t utf8_encode(input logic [CP_W-1:0] cp);
    utf8_t r;
    r.len   = 3'd0;
    r.bytes = '0;
    if (cp < CP_W'(32'h80)) begin
      r.len      = 3'd1;
      r.bytes[0] = cp[7:0];
    end else if (cp < CP_W'(32'h800)) begin
      r.len      = 3'd2;
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < CP_W'(32'h10000)) begin
      r.len      = 3'd3;
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      r.len      = 3'd4;
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/jsu_front.sv */
`default_nettype none

module jsu_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           in_eoi,
  input  wire logic [7:0]     in_byte,
  input  wire logic           q_full,
  output logic                push,
  output jsu_pkg::entry_t     push_entry
);

  typedef enum logic [1:0] {
    M_WAIT = 2'd0,
    M_STR  = 2'd1,
    M_ESC  = 2'd2,
    M_HEX  = 2'd3
  } mode_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CTRL_MAX  = 8'h1F;
  localparam logic [15:0] HI_SUR_LO = 16'hD800;
  localparam logic [15:0] HI_SUR_HI = 16'hDBFF;
  localparam logic [15:0] LO_SUR_LO = 16'hDC00;
  localparam logic [15:0] LO_SUR_HI = 16'hDFFF;
  localparam logic [jsu_pkg::CP_W-1:0] SUPP_BASE = jsu_pkg::CP_W'(32'h10000);

  mode_t       mode_r, mode_nxt;
  logic [1:0]  hex_cnt_r, hex_cnt_nxt;
  logic [11:0] hex_acc_r, hex_acc_nxt;
  logic        held_vld_r, held_vld_nxt;
  logic [15:0] held_pt_r, held_pt_nxt;

  logic            fire;
  jsu_pkg::utf8_t  held_enc;
  jsu_pkg::utf8_t  pair_enc;
  logic [2:0]      held_len;
  logic [15:0]     cp;
  logic [4:0]      hex_d;
  logic            esc_ok;
  logic [7:0]      esc_char;
  logic            pair;
  jsu_pkg::entry_t ent;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;

  // Encodings of the held code point and of a completed surrogate pair.
  assign held_enc = jsu_pkg::utf8_encode(jsu_pkg::CP_W'(held_pt_r));
  assign held_len = held_vld_r ? held_enc.len : 3'd0;
  assign pair_enc = jsu_pkg::utf8_encode(
      jsu_pkg::CP_W'({held_pt_r[9:0], cp[9:0]}) + SUPP_BASE);

  // Hex digit value; bit 4 set marks a byte that is not a hex digit.
  always_comb begin
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_d = {1'b0, in_byte[3:0]};
    end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
      hex_d = {1'b0, in_byte[3:0] + 4'd9};
    end else begin
      hex_d = 5'h10;
    end
  end

  assign cp   = {hex_acc_r, hex_d[3:0]};
  assign pair = held_vld_r && held_pt_r >= HI_SUR_LO && held_pt_r <= HI_SUR_HI &&
                cp >= LO_SUR_LO && cp <= LO_SUR_HI;

  // Single-letter escapes.
  always_comb begin
    esc_ok   = 1'b1;
    esc_char = in_byte;
    case (in_byte)
      CH_B:      esc_char = 8'h08;
      CH_F:      esc_char = 8'h0C;
      CH_N:      esc_char = 8'h0A;
      CH_R:      esc_char = 8'h0D;
      CH_T:      esc_char = 8'h09;
      CH_QUOTE:  esc_char = in_byte;
      CH_BSLASH: esc_char = in_byte;
      CH_SLASH:  esc_char = in_byte;
      default:   esc_ok   = 1'b0;
    endcase
  end

  // Parser: next state and the results of the accepted request.
  always_comb begin
    mode_nxt     = mode_r;
    hex_cnt_nxt  = hex_cnt_r;
    hex_acc_nxt  = hex_acc_r;
    held_vld_nxt = held_vld_r;
    held_pt_nxt  = held_pt_r;
    ent          = '0;
    ent.tail_kind = jsu_pkg::KIND_TEXT;
    ent.tail_err  = jsu_pkg::ERR_NONE;

    if (fire) begin
      if (in_eoi) begin
        ent.tail_vld  = 1'b1;
        ent.tail_kind = jsu_pkg::KIND_ERROR;
        ent.tail_err  = jsu_pkg::ERR_EOI;
        mode_nxt      = M_WAIT;
        hex_cnt_nxt   = 2'd0;
        held_vld_nxt  = 1'b0;
      end else begin
        case (mode_r)
          M_WAIT: begin
            if (in_byte == CH_QUOTE) begin
              mode_nxt = M_STR;
            end else begin
              ent.tail_vld  = 1'b1;
              ent.tail_kind = jsu_pkg::KIND_NOTSTR;
            end
          end
          M_STR: begin
            if (in_byte == CH_QUOTE) begin
              // Flush any held code point, then report the close.
              ent.n_text    = held_len;
              ent.text      = held_vld_r ? held_enc.bytes : '0;
              ent.tail_vld  = 1'b1;
              ent.tail_kind = jsu_pkg::KIND_CLOSED;
              mode_nxt      = M_WAIT;
              held_vld_nxt  = 1'b0;
            end else if (in_byte <= CTRL_MAX) begin
              ent.tail_vld  = 1'b1;
              ent.tail_kind = jsu_pkg::KIND_ERROR;
              ent.tail_err  = jsu_pkg::ERR_CTRL;
              mode_nxt      = M_WAIT;
              held_vld_nxt  = 1'b0;
            end else if (in_byte == CH_BSLASH) begin
              mode_nxt = M_ESC;
            end else begin
              ent.text                = held_vld_r ? held_enc.bytes : '0;
              ent.text[held_len[1:0]] = in_byte;
              ent.n_text              = held_len + 3'd1;
              held_vld_nxt            = 1'b0;
            end
          end
          M_ESC: begin
            if (in_byte == CH_U) begin
              mode_nxt    = M_HEX;
              hex_cnt_nxt = 2'd0;
              hex_acc_nxt = '0;
            end else if (!esc_ok) begin
              ent.tail_vld  = 1'b1;
              ent.tail_kind = jsu_pkg::KIND_ERROR;
              ent.tail_err  = jsu_pkg::ERR_ESC;
              mode_nxt      = M_WAIT;
              held_vld_nxt  = 1'b0;
            end else begin
              ent.text                = held_vld_r ? held_enc.bytes : '0;
              ent.text[held_len[1:0]] = esc_char;
              ent.n_text              = held_len + 3'd1;
              held_vld_nxt            = 1'b0;
              mode_nxt                = M_STR;
            end
          end
          M_HEX: begin
            if (hex_d[4]) begin
              ent.tail_vld  = 1'b1;
              ent.tail_kind = jsu_pkg::KIND_ERROR;
              ent.tail_err  = jsu_pkg::ERR_HEX;
              mode_nxt      = M_WAIT;
              hex_cnt_nxt   = 2'd0;
              held_vld_nxt  = 1'b0;
            end else if (hex_cnt_r != 2'd3) begin
              hex_acc_nxt = cp[11:0];
              hex_cnt_nxt = hex_cnt_r + 2'd1;
            end else begin
              if (pair) begin
                // High surrogate held, low surrogate now: one supplementary character.
                ent.n_text   = pair_enc.len;
                ent.text     = pair_enc.bytes;
                held_vld_nxt = 1'b0;
              end else begin
                ent.n_text   = held_len;
                ent.text     = held_vld_r ? held_enc.bytes : '0;
                held_vld_nxt = 1'b1;
                held_pt_nxt  = cp;
              end
              hex_cnt_nxt = 2'd0;
              mode_nxt    = M_STR;
            end
          end
          default: mode_nxt = M_WAIT;
        endcase
      end
    end
  end

  assign push       = fire && (ent.n_text != 3'd0 || ent.tail_vld);
  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_WAIT;
      hex_cnt_r  <= 2'd0;
      held_vld_r <= 1'b0;
    end else begin
      mode_r     <= mode_nxt;
      hex_cnt_r  <= hex_cnt_nxt;
      held_vld_r <= held_vld_nxt;
    end
  end

  // Payload state needs no reset: it is only read once written.
  always_ff @(posedge clk) begin
    hex_acc_r <= hex_acc_nxt;
    held_pt_r <= held_pt_nxt;
  end

  // An error result never travels with text.
  assert property (@(posedge clk) disable iff (!rst_n)
    push && push_entry.tail_kind == jsu_pkg::KIND_ERROR && push_entry.tail_vld
      |-> push_entry.n_text == 3'd0)
    else $error("error result queued together with text bytes");

  // At most four results per request.
  assert property (@(posedge clk) disable iff (!rst_n)
    push |-> ({1'b0, push_entry.n_text} + {3'b0, push_entry.tail_vld}) <= 4'd4)
    else $error("more than four results queued for one request");

  // Something is held only while inside a string.
  assert property (@(posedge clk) disable iff (!rst_n)
    held_vld_r |-> mode_r != M_WAIT)
    else $error("code point held outside a string");

endmodule

`default_nettype wire

/* hdl/jsu_fifo.sv */
`default_nettype none

module jsu_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire jsu_pkg::entry_t push_entry,
  input  wire logic            pop,
  output jsu_pkg::entry_t      head,
  output logic                 full,
  output logic                 empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  jsu_pkg::entry_t slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full  = count_r == CW'(DEPTH);
  assign empty = count_r == '0;
  assign head  = slot_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  // No write into a full queue.
  assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue overflow");

  // No read from an empty queue.
  assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue underflow");

endmodule

`default_nettype wire

/* hdl/jsu_back.sv */
`default_nettype none

module jsu_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire jsu_pkg::entry_t head,
  input  wire logic            empty,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_byte,
  output jsu_pkg::kind_t       out_kind,
  output jsu_pkg::err_t        out_err,
  output logic                 out_last
);

  logic [1:0]     idx_r, idx_nxt;
  logic           vld_r;
  logic [7:0]     byte_r;
  jsu_pkg::kind_t kind_r;
  jsu_pkg::err_t  err_r;
  logic           last_r;

  logic           load;
  logic [2:0]     total;
  logic           is_last;
  logic           is_text;

  // The output register takes a new result when empty or being drained.
  assign load    = !empty && (!vld_r || out_ready);
  assign total   = head.n_text + {2'b0, head.tail_vld};
  assign is_last = {1'b0, idx_r} == total - 3'd1;
  assign is_text = {1'b0, idx_r} < head.n_text;
  assign pop     = load && is_last;

  assign idx_nxt = load ? (is_last ? 2'd0 : idx_r + 2'd1) : idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (load) begin
        vld_r <= 1'b1;
      end else if (out_ready) begin
        vld_r <= 1'b0;
      end
    end
  end

  // Result payload: text bytes first, then the tail result.
  always_ff @(posedge clk) begin
    if (load) begin
      last_r <= is_last;
      if (is_text) begin
        byte_r <= head.text[idx_r];
        kind_r <= jsu_pkg::KIND_TEXT;
        err_r  <= jsu_pkg::ERR_NONE;
      end else begin
        byte_r <= 8'h00;
        kind_r <= head.tail_kind;
        err_r  <= head.tail_err;
      end
    end
  end

  assign out_valid = vld_r;
  assign out_byte  = byte_r;
  assign out_kind  = kind_r;
  assign out_err   = err_r;
  assign out_last  = last_r;

  // The index only moves past zero while an entry is being worked off.
  assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != 2'd0 |-> !empty)
    else $error("serializer mid-entry with the queue empty");

endmodule

`default_nettype wire

/* hdl/json_string_unescape_utf8.sv */
`default_nettype none
// Path: a request's results go into the queue, then one by one into the output register.
// Throughput: one request per cycle while the queue is not full and one result per cycle
// while the receiver is ready; the queue of QUEUE_DEPTH entries lets the parser run
// ahead. Requests that give no result take no queue slot.
// Reset: synchronous, active low; the parser waits for an opening quote, queue empty.

module json_string_unescape_utf8 #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] op (1 = end of input)
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] out_byte, [10:8] error_code, [15:11] zero
  output logic [1:0]       out_tuser,  // [1:0] kind
  output logic             out_tlast
);

  jsu_pkg::entry_t push_entry;
  jsu_pkg::entry_t head;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;
  logic [7:0]      res_byte;
  jsu_pkg::kind_t  res_kind;
  jsu_pkg::err_t   res_err;

  // Parser: accepts and classifies input bytes.
  jsu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_eoi     (in_tuser),
    .in_byte    (in_tdata),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Result groups waiting to be serialized.
  jsu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty)
  );

  // Serializer: one result per cycle into the output register while the receiver is ready.
  jsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (res_byte),
    .out_kind  (res_kind),
    .out_err   (res_err),
    .out_last  (out_tlast)
  );

  assign out_tdata = {5'b0, res_err, res_byte};
  assign out_tuser = res_kind;

endmodule

`default_nettype wire

/* test/json_string_unescape_utf8_test.sv */
module json_string_unescape_utf8_test;

  // ASCII bytes that steer the string parser.
  localparam logic [7:0] QUOTE    = 8'h22;
  localparam logic [7:0] BSLASH   = 8'h5C;
  localparam logic [7:0] LETTER_U = 8'h75;
  // Escape letters: b f n r t, quote, backslash, slash.
  localparam logic [63:0] ESC_LETTERS = {8'h62, 8'h66, 8'h6E, 8'h72,
                                         8'h74, 8'h22, 8'h5C, 8'h2F};
  localparam logic [15:0] HIGH_SURR_LO = 16'hD800;
  localparam logic [15:0] HIGH_SURR_HI = 16'hDBFF;
  localparam logic [15:0] LOW_SURR_LO  = 16'hDC00;
  localparam logic [15:0] LOW_SURR_HI  = 16'hDFFF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_TARGET = 470;

  typedef enum logic [1:0] {
    SCAN_WAIT   = 2'd0,
    SCAN_STRING = 2'd1,
    SCAN_ESCAPE = 2'd2,
    SCAN_HEX    = 2'd3
  } scan_t;

  // One input request; hold_for_drain makes the sender wait for all results first.
  typedef struct packed {
    logic       hold_for_drain;
    logic       end_of_input;
    logic [7:0] data;
  } byte_req_t;

  typedef struct packed {
    logic [7:0]     data;
    jsu_pkg::kind_t kind;
    jsu_pkg::err_t  code;
    logic           last;
  } utf8_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  byte_req_t    bytes_to_send[$];
  utf8_result_t expected_utf8[$];

  // Shadow copy of the parser state.
  scan_t       scan_mode = SCAN_WAIT;
  logic [1:0]  digit_count = 2'd0;
  logic [15:0] digit_accum = 16'h0000;
  logic        held_valid = 1'b0;
  logic [15:0] held_point = 16'h0000;

  logic req_taken = 1'b0;
  int   error_count = 0;
  int   cycle_count = 0;
  int   burst_left = 4;
  int   gap_left = 0;
  int   stall_style = 0;
  int   stall_timer = 0;
  logic [31:0] stall_pattern = 32'hFFFF_FFFF;

  json_string_unescape_utf8 dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Byte value of a simple escape letter; bit 8 set means not a valid escape.
  function automatic logic [8:0] escape_value(input logic [7:0] b);
    case (b)
      8'h62: return 9'h008;
      8'h66: return 9'h00C;
      8'h6E: return 9'h00A;
      8'h72: return 9'h00D;
      8'h74: return 9'h009;
      QUOTE, BSLASH, 8'h2F: return {1'b0, b};
      default: return 9'h100;
    endcase
  endfunction

  // Value of a hex digit; 16 means the byte is not a hex digit.
  function automatic logic [4:0] hex_digit_value(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return 5'(b - 8'h30);
    if (b >= 8'h61 && b <= 8'h66) return 5'(b - 8'h61 + 8'd10);
    if (b >= 8'h41 && b <= 8'h46) return 5'(b - 8'h41 + 8'd10);
    return 5'd16;
  endfunction

  // ASCII hex digit for a nibble, letters in random case.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + {4'h0, nib};
    if ($urandom_range(0, 1) == 0) return 8'h61 + {4'h0, nib} - 8'd10;
    return 8'h41 + {4'h0, nib} - 8'd10;
  endfunction

  task automatic push_result(input logic [7:0] d, input jsu_pkg::kind_t k,
                             input jsu_pkg::err_t e);
    utf8_result_t r;
    r.data = d;
    r.kind = k;
    r.code = e;
    r.last = 1'b0;
    expected_utf8 = {expected_utf8, r};
  endtask

  task automatic emit_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      push_result(cp[7:0], jsu_pkg::KIND_TEXT, jsu_pkg::ERR_NONE);
    end else if (cp < 21'h800) begin
      push_result({3'b110, cp[10:6]}, jsu_pkg::KIND_TEXT, jsu_pkg::ERR_NONE);
      push_result({2'b10, cp[5:0]}, jsu_pkg::KIND_TEXT, jsu_pkg::ERR_NONE);
    end else if (cp < 21'h10000) begin
      push_result({4'b1110, cp[15:12]}, jsu_pkg::KIND_TEXT, jsu_pkg::ERR_NONE);
      push_result({2'b10, cp[11:6]}, jsu_pkg::KIND_TEXT, jsu_pkg::ERR_NONE);
      push_result({2'b10, cp[5:0]}, jsu_pkg::KIND_TEXT, jsu_pkg::ERR_NONE);
    end else begin
      push_result({5'b11110, cp[20:18]}, jsu_pkg::KIND_TEXT, jsu_pkg::ERR_NONE);
      push_result({2'b10, cp[17:12]}, jsu_pkg::KIND_TEXT, jsu_pkg::ERR_NONE);
      push_result({2'b10, cp[11:6]}, jsu_pkg::KIND_TEXT, jsu_pkg::ERR_NONE);
      push_result({2'b10, cp[5:0]}, jsu_pkg::KIND_TEXT, jsu_pkg::ERR_NONE);
    end
  endtask

  task automatic flush_held_point();
    if (held_valid) emit_code_point({5'd0, held_point});
    held_valid = 1'b0;
    held_point = 16'h0000;
  endtask

  task automatic clear_parser();
    scan_mode = SCAN_WAIT;
    digit_count = 2'd0;
    digit_accum = 16'h0000;
    held_valid = 1'b0;
    held_point = 16'h0000;
  endtask

  // An error drops anything held and sends the parser back to waiting.
  task automatic abort_string(input jsu_pkg::err_t e);
    clear_parser();
    push_result(8'h00, jsu_pkg::KIND_ERROR, e);
  endtask

  // Work out the results that one accepted request causes.
  task automatic predict_unescape(input logic end_of_input, input logic [7:0] b);
    int unsigned  first;
    logic [8:0]   esc;
    logic [4:0]   dig;
    logic [15:0]  cp;
    utf8_result_t r;
    first = expected_utf8.size();
    esc = escape_value(b);
    dig = hex_digit_value(b);
    cp = {digit_accum[11:0], dig[3:0]};
    if (end_of_input) begin
      abort_string(jsu_pkg::ERR_EOI);
    end else begin
      case (scan_mode)
        SCAN_WAIT: begin
          if (b == QUOTE) begin
            clear_parser();
            scan_mode = SCAN_STRING;
          end else begin
            push_result(8'h00, jsu_pkg::KIND_NOTSTR, jsu_pkg::ERR_NONE);
          end
        end
        SCAN_STRING: begin
          if (b == QUOTE) begin
            flush_held_point();
            push_result(8'h00, jsu_pkg::KIND_CLOSED, jsu_pkg::ERR_NONE);
            clear_parser();
          end else if (b < 8'h20) begin
            abort_string(jsu_pkg::ERR_CTRL);
          end else if (b == BSLASH) begin
            scan_mode = SCAN_ESCAPE;
          end else begin
            flush_held_point();
            push_result(b, jsu_pkg::KIND_TEXT, jsu_pkg::ERR_NONE);
          end
        end
        SCAN_ESCAPE: begin
          if (b == LETTER_U) begin
            scan_mode = SCAN_HEX;
            digit_count = 2'd0;
            digit_accum = 16'h0000;
          end else if (esc[8]) begin
            abort_string(jsu_pkg::ERR_ESC);
          end else begin
            flush_held_point();
            push_result(esc[7:0], jsu_pkg::KIND_TEXT, jsu_pkg::ERR_NONE);
            scan_mode = SCAN_STRING;
          end
        end
        default: begin
          if (dig[4]) begin
            abort_string(jsu_pkg::ERR_HEX);
          end else if (digit_count != 2'd3) begin
            digit_accum = cp;
            digit_count = digit_count + 2'd1;
          end else begin
            // A held high surrogate and a new low surrogate make one character.
            if (held_valid && held_point >= HIGH_SURR_LO && held_point <= HIGH_SURR_HI &&
                cp >= LOW_SURR_LO && cp <= LOW_SURR_HI) begin
              emit_code_point(21'h10000 + {1'b0, held_point[9:0], cp[9:0]});
              held_valid = 1'b0;
              held_point = 16'h0000;
            end else begin
              flush_held_point();
              held_valid = 1'b1;
              held_point = cp;
            end
            digit_count = 2'd0;
            digit_accum = 16'h0000;
            scan_mode = SCAN_STRING;
          end
        end
      endcase
    end
    if (expected_utf8.size() > first) begin
      r = expected_utf8[expected_utf8.size() - 1];
      r.last = 1'b1;
      expected_utf8[expected_utf8.size() - 1] = r;
    end
  endtask

  task automatic add_req(input logic eoi, input logic [7:0] d, input logic drain);
    byte_req_t q;
    q.hold_for_drain = drain;
    q.end_of_input = eoi;
    q.data = d;
    bytes_to_send = {bytes_to_send, q};
  endtask

  task automatic add_hex_escape(input logic [15:0] cp);
    add_req(1'b0, BSLASH, 1'b0);
    add_req(1'b0, LETTER_U, 1'b0);
    add_req(1'b0, hex_char(cp[15:12]), 1'b0);
    add_req(1'b0, hex_char(cp[11:8]), 1'b0);
    add_req(1'b0, hex_char(cp[7:4]), 1'b0);
    add_req(1'b0, hex_char(cp[3:0]), 1'b0);
  endtask

  // Backslash, u and up to three good digits, the start of a hex escape cut short.
  task automatic add_partial_hex();
    add_req(1'b0, BSLASH, 1'b0);
    add_req(1'b0, LETTER_U, 1'b0);
    repeat ($urandom_range(0, 3)) add_req(1'b0, hex_char(4'($urandom_range(0, 15))), 1'b0);
  endtask

  // One quoted string with random content, mostly well formed.
  task automatic add_random_string();
    logic [7:0]  b;
    logic [8:0]  esc;
    logic [4:0]  dig;
    logic [15:0] cp;
    add_req(1'b0, QUOTE, $urandom_range(0, 24) == 0);
    repeat ($urandom_range(0, 7)) begin
      case ($urandom_range(0, 5))
        0, 1: begin
          do b = 8'($urandom_range(32, 255)); while (b == QUOTE || b == BSLASH);
          add_req(1'b0, b, 1'b0);
        end
        2: begin
          add_req(1'b0, BSLASH, 1'b0);
          add_req(1'b0, ESC_LETTERS[8*$urandom_range(0, 7) +: 8], 1'b0);
        end
        default: begin
          case ($urandom_range(0, 6))
            0: cp = 16'($urandom);
            1: cp = 16'($urandom_range(0, 16'h7F));
            2: cp = 16'($urandom_range(16'h80, 16'h7FF));
            3: cp = 16'($urandom_range(HIGH_SURR_LO, HIGH_SURR_HI));
            4: cp = 16'($urandom_range(LOW_SURR_LO, LOW_SURR_HI));
            5: begin
              add_hex_escape(16'($urandom_range(HIGH_SURR_LO, HIGH_SURR_HI)));
              cp = 16'($urandom_range(LOW_SURR_LO, LOW_SURR_HI));
            end
            default: cp = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'h0000;
          endcase
          add_hex_escape(cp);
        end
      endcase
    end
    // How the string ends: closed, or broken in one of several ways.
    case ($urandom_range(0, 12))
      7: add_req(1'b0, 8'($urandom_range(0, 31)), 1'b0);
      8: begin
        do begin
          b = 8'($urandom);
          esc = escape_value(b);
        end while (!esc[8] || b == LETTER_U);
        add_req(1'b0, BSLASH, 1'b0);
        add_req(1'b0, b, 1'b0);
      end
      9: begin
        do begin
          b = 8'($urandom);
          dig = hex_digit_value(b);
        end while (!dig[4]);
        add_partial_hex();
        add_req(1'b0, b, 1'b0);
      end
      10: add_req(1'b1, 8'($urandom), 1'b0);
      11: begin
        add_req(1'b0, BSLASH, 1'b0);
        add_req(1'b1, 8'($urandom), 1'b0);
      end
      12: begin
        add_partial_hex();
        add_req(1'b1, 8'($urandom), 1'b0);
      end
      default: add_req(1'b0, QUOTE, 1'b0);
    endcase
    // Some noise while the parser waits for an opening quote.
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 3) == 0) begin
          add_req(1'b1, 8'($urandom), 1'b0);
        end else begin
          do b = 8'($urandom); while (b == QUOTE);
          add_req(1'b0, b, 1'b0);
        end
      end
    end
  endtask

  // Sender: bursts of requests with random gaps, changed at the falling edge.
  always @(negedge clk) begin
    byte_req_t q;
    if (rst_n && (!in_tvalid || req_taken)) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (bytes_to_send.size() == 0 ||
                   (bytes_to_send[0].hold_for_drain && expected_utf8.size() != 0)) begin
        in_tvalid <= 1'b0;
      end else begin
        q = bytes_to_send.pop_front();
        in_tdata <= q.data;
        in_tuser <= q.end_of_input;
        in_tvalid <= 1'b1;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) :
                                                     $urandom_range(1, 10);
        end
      end
    end
  end

  // Receiver: switches between stall styles, each kept for a random stretch.
  always @(negedge clk) begin
    logic ready;
    ready = 1'b1;
    if (rst_n) begin
      if (stall_timer == 0) begin
        stall_style = $urandom_range(0, 3);
        stall_timer = $urandom_range(20, 120);
        stall_pattern = $urandom;
      end else begin
        stall_timer = stall_timer - 1;
      end
      case (stall_style)
        1: ready = ($urandom_range(0, 3) != 0);
        2: ready = ($urandom_range(0, 1) != 0);
        3: begin
          ready = stall_pattern[0];
          stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
        end
        default: ready = 1'b1;
      endcase
      out_tready <= ready;
    end
  end

  // Monitor: predicts on each accepted request and checks each accepted result.
  always @(posedge clk) begin
    utf8_result_t r;
    if (rst_n) begin
      req_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) predict_unescape(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        if (expected_utf8.size() == 0) begin
          if (error_count < 10)
            $display("cycle %0d: unexpected result tdata %h kind %0d last %b",
                     cycle_count, out_tdata, out_tuser, out_tlast);
          error_count = error_count + 1;
        end else begin
          r = expected_utf8.pop_front();
          if (out_tdata[7:0] !== r.data || out_tuser !== r.kind ||
              out_tdata[10:8] !== r.code || out_tdata[15:11] !== 5'd0 ||
              out_tlast !== r.last) begin
            if (error_count < 10)
              $display({"cycle %0d: expected byte %h kind %0d err %0d last %b, ",
                        "got tdata %h kind %0d last %b"}, cycle_count, r.data, r.kind,
                       r.code, r.last, out_tdata, out_tuser, out_tlast);
            error_count = error_count + 1;
          end
        end
      end
    end
  end

  // Watchdog on the total run time.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    // Directed part: end of input while waiting, a stray byte, a surrogate pair,
    // then a control byte, a bad escape letter and a bad hex digit.
    add_req(1'b1, 8'hFF, 1'b0);
    add_req(1'b0, 8'h00, 1'b0);
    add_req(1'b0, QUOTE, 1'b0);
    add_hex_escape(16'hD83D);
    add_hex_escape(16'hDE00);
    add_req(1'b0, QUOTE, 1'b0);
    add_req(1'b0, QUOTE, 1'b0);
    add_req(1'b0, 8'h1F, 1'b0);
    add_req(1'b0, QUOTE, 1'b0);
    add_req(1'b0, BSLASH, 1'b0);
    add_req(1'b0, 8'h78, 1'b0);
    add_req(1'b0, QUOTE, 1'b0);
    add_req(1'b0, BSLASH, 1'b0);
    add_req(1'b0, LETTER_U, 1'b0);
    add_req(1'b0, 8'h67, 1'b0);

    // A string holding byte FF waits until everything before it has drained.
    add_req(1'b0, QUOTE, 1'b1);
    add_req(1'b0, 8'hFF, 1'b0);
    add_req(1'b0, QUOTE, 1'b0);
    while (bytes_to_send.size() < RANDOM_TARGET) add_random_string();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (bytes_to_send.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_utf8.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
